[hdl/dcr_pkg.sv]
// Shared types and constants of the DMA channel register, arbiter and interrupt block.
`timescale 1ns / 1ps

package dcr_pkg;

    // Item kinds.
    localparam logic [1:0] OpRead  = 2'd0;
    localparam logic [1:0] OpWrite = 2'd1;
    localparam logic [1:0] OpDone  = 2'd2;

    // Register selects within a channel group.
    localparam logic [3:0] RegAddr  = 4'h0;
    localparam logic [3:0] RegBlock = 4'h4;
    localparam logic [3:0] RegCtrl  = 4'h8;

    // Channel codes.
    localparam logic [2:0] NoneCh   = 3'd7;
    localparam logic [2:0] GlobalCh = 3'd7;
    localparam logic [2:0] OtcCh    = 3'd6;

    localparam int StartBit   = 24;
    localparam int TriggerBit = 28;

    localparam logic [31:0] PrioReset   = 32'h0765_4321;
    localparam logic [31:0] IrqKeepMask = 32'h7f00_0000;
    localparam logic [31:0] IrqWrMask   = 32'h00ff_803f;
    localparam logic [31:0] CtrlMask    = 32'h7177_0703;
    localparam logic [31:0] OtcCtrlMask = 32'h5100_0002;
    localparam logic [31:0] OtcCtrlSet  = 32'h0000_0002;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  offset;
        logic [31:0] write_value;
        logic [2:0]  done_channel;
        logic [23:0] final_address;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_raise;
        logic [2:0]  run_channel;
        logic        channel_started;
    } out_beat_t;

endpackage

[hdl/dcr_ifs.sv]
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps

interface dcr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [6:0]  offset;
    logic [31:0] write_value;
    logic [2:0]  done_channel;
    logic [23:0] final_address;

    modport source (output valid, op, offset, write_value, done_channel, final_address,
                    input ready);
    modport sink   (input valid, op, offset, write_value, done_channel, final_address,
                    output ready);
endinterface

interface dcr_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_raise;
    logic [2:0]  run_channel;
    logic        channel_started;

    modport source (output valid, read_data, irq_raise, run_channel, channel_started,
                    input ready);
    modport sink   (input valid, read_data, irq_raise, run_channel, channel_started,
                    output ready);
endinterface

[hdl/dcr_arbiter.sv]
// Fixed priority arbiter over the busy channels.
`timescale 1ns / 1ps

module dcr_arbiter #(
    parameter int NUM_CHANNELS = 7
) (
    input  logic [NUM_CHANNELS-1:0] busy,
    input  logic [31:0]             prio,
    output logic [2:0]              pick
);

    // Expanded key is 8 + 8p - i; keys are unique, the lowest wins.
    always_comb
    begin
        logic [6:0] best_key;
        logic [6:0] key;
        best_key = 7'h7f;
        pick     = dcr_pkg::NoneCh;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            key = 7'd8 + {1'b0, prio[4*i +: 3], 3'b000} - 7'(i);
            if (busy[i] && (key < best_key))
            begin
                best_key = key;
                pick     = 3'(i);
            end
        end
    end

endmodule

[hdl/dcr_regs.sv]
// Channel and global register state with the write, start, stop and done logic.
`timescale 1ns / 1ps

module dcr_regs #(
    parameter int NUM_CHANNELS = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  dcr_pkg::in_beat_t  item,
    output dcr_pkg::out_beat_t result,
    output logic [2:0]         cur_channel
);

    localparam int ChW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [23:0] addr_reg  [NUM_CHANNELS];
    logic [31:0] block_reg [NUM_CHANNELS];
    logic [31:0] ctrl_reg  [NUM_CHANNELS];
    logic [31:0] prio_reg;
    logic [31:0] prio_next;
    logic [31:0] irqc_reg;
    logic [31:0] irqc_next;
    logic [NUM_CHANNELS-1:0] busy_reg;
    logic [NUM_CHANNELS-1:0] busy_next;
    logic [2:0]  cur_reg;
    logic [2:0]  cur_next;

    logic [2:0]     ch;
    logic [3:0]     rsel;
    logic [2:0]     sel;
    logic           sel_ok;
    logic [ChW-1:0] idx;
    logic [23:0]    rd_addr;
    logic [31:0]    rd_block;
    logic [31:0]    rd_ctrl;
    logic           addr_we;
    logic [23:0]    addr_wval;
    logic           block_we;
    logic           ctrl_we;
    logic [31:0]    ctrl_wval;
    logic           pick_req;
    logic [2:0]     pick_ch;
    logic [31:0]    rdata;
    logic           irq;
    logic           is_otc;

    assign ch     = item.offset[6:4];
    assign rsel   = item.offset[3:0];
    assign sel    = (item.op == dcr_pkg::OpDone) ? item.done_channel : ch;
    assign sel_ok = (sel < 3'(NUM_CHANNELS));
    assign idx    = sel[ChW-1:0];
    assign is_otc = (ch == dcr_pkg::OtcCh);

    assign rd_addr  = addr_reg[idx];
    assign rd_block = block_reg[idx];
    assign rd_ctrl  = ctrl_reg[idx];

    // Priority never changes in the same beat as a busy flag, so the
    // arbiter sees the stored priorities and the updated busy set.
    dcr_arbiter #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_arbiter (
        .busy (busy_next),
        .prio (prio_reg),
        .pick (pick_ch)
    );

    always_comb
    begin
        prio_next = prio_reg;
        irqc_next = irqc_reg;
        busy_next = busy_reg;
        addr_we   = 1'b0;
        addr_wval = item.write_value[23:0];
        block_we  = 1'b0;
        ctrl_we   = 1'b0;
        ctrl_wval = 32'h0;
        pick_req  = 1'b0;
        rdata     = 32'h0;
        irq       = 1'b0;

        case (item.op)
            dcr_pkg::OpRead:
            begin
                if (ch == dcr_pkg::GlobalCh)
                begin
                    rdata = item.offset[2] ? irqc_reg : prio_reg;
                end
                else if (sel_ok)
                begin
                    case (rsel)
                        dcr_pkg::RegAddr:  rdata = {8'h00, rd_addr};
                        dcr_pkg::RegBlock: rdata = rd_block;
                        dcr_pkg::RegCtrl:  rdata = rd_ctrl;
                        default:           rdata = 32'h0;
                    endcase
                end
            end
            dcr_pkg::OpWrite:
            begin
                if (ch == dcr_pkg::GlobalCh)
                begin
                    if (item.offset[2])
                    begin
                        // Flags written as one are acknowledged; bit 31 always clears.
                        irqc_next = ((irqc_reg & dcr_pkg::IrqKeepMask) & ~item.write_value)
                                  | (item.write_value & dcr_pkg::IrqWrMask);
                    end
                    else
                    begin
                        prio_next = item.write_value;
                    end
                end
                else if (sel_ok)
                begin
                    case (rsel)
                        dcr_pkg::RegAddr:  addr_we  = 1'b1;
                        dcr_pkg::RegBlock: block_we = 1'b1;
                        dcr_pkg::RegCtrl:
                        begin
                            ctrl_we   = 1'b1;
                            ctrl_wval = is_otc
                                ? ((item.write_value | dcr_pkg::OtcCtrlSet) & dcr_pkg::OtcCtrlMask)
                                : (item.write_value & dcr_pkg::CtrlMask);
                            if (item.write_value[dcr_pkg::StartBit])
                            begin
                                if (prio_reg[{ch, 2'b11}])
                                begin
                                    // Burst mode drops the trigger bit on start.
                                    if (is_otc || (ctrl_wval[10:9] == 2'b00))
                                    begin
                                        ctrl_wval[dcr_pkg::TriggerBit] = 1'b0;
                                    end
                                    busy_next[idx] = 1'b1;
                                    pick_req       = 1'b1;
                                end
                            end
                            else if (busy_reg[idx])
                            begin
                                busy_next[idx] = 1'b0;
                                pick_req       = (cur_reg == ch);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dcr_pkg::OpDone:
            begin
                if (sel_ok && busy_reg[idx])
                begin
                    addr_we   = 1'b1;
                    addr_wval = item.final_address;
                    ctrl_we   = 1'b1;
                    ctrl_wval = rd_ctrl;
                    ctrl_wval[dcr_pkg::StartBit] = 1'b0;
                    if (irqc_reg[{2'b10, sel}])
                    begin
                        irqc_next[{2'b11, sel}] = 1'b1;
                        if (irqc_reg[23])
                        begin
                            irqc_next[31] = 1'b1;
                            irq           = 1'b1;
                        end
                    end
                    busy_next[idx] = 1'b0;
                    pick_req       = (cur_reg == sel);
                end
            end
            default: ;
        endcase

        cur_next = pick_req ? pick_ch : cur_reg;
    end

    assign result.read_data       = rdata;
    assign result.irq_raise       = irq;
    assign result.run_channel     = cur_next;
    assign result.channel_started = (cur_next != dcr_pkg::NoneCh) && (cur_next != cur_reg);
    assign cur_channel            = cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                addr_reg[i]  <= 24'h0;
                block_reg[i] <= 32'h0;
                ctrl_reg[i]  <= 32'h0;
            end
            prio_reg <= dcr_pkg::PrioReset;
            irqc_reg <= 32'h0;
            busy_reg <= '0;
            cur_reg  <= dcr_pkg::NoneCh;
        end
        else if (commit)
        begin
            if (addr_we)
            begin
                addr_reg[idx] <= addr_wval;
            end
            if (block_we)
            begin
                block_reg[idx] <= item.write_value;
            end
            if (ctrl_we)
            begin
                ctrl_reg[idx] <= ctrl_wval;
            end
            prio_reg <= prio_next;
            irqc_reg <= irqc_next;
            busy_reg <= busy_next;
            cur_reg  <= cur_next;
        end
    end

endmodule

[hdl/dma_channel_regs_arbiter_irq.sv]
// Top level: request register, register/arbiter core and response register.
// Request beats pass the request register, then the core, then the response register.
// Throughput: one beat per cycle, sustained while the response side keeps ready high.
// The rate is set by the core pass between request and response registers, which
// updates all channel state in the same cycle it computes the result.
// Reset (rst_n, async, active low) empties both stages, clears the registers,
// loads priority 0x07654321 and marks no channel active.
`timescale 1ns / 1ps

module dma_channel_regs_arbiter_irq #(
    parameter int NUM_CHANNELS = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    dcr_req_if.sink    req,
    dcr_rsp_if.source  rsp
);

    // Request stage holds one beat; it hands over to the response stage when
    // that stage is empty or its beat is being taken this cycle.
    logic                s1_valid_reg;
    dcr_pkg::in_beat_t   s1_item_reg;
    logic                rsp_valid_reg;
    dcr_pkg::out_beat_t  rsp_beat_reg;
    logic                adv;
    dcr_pkg::out_beat_t  core_result;
    logic [2:0]          cur_channel;
    logic                req_fire;

    assign adv       = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || adv;
    assign req_fire  = req.valid && req.ready;

    // The core commits its state update exactly when the beat moves on.
    dcr_regs #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (adv),
        .item        (s1_item_reg),
        .result      (core_result),
        .cur_channel (cur_channel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_item_reg.op            <= req.op;
            s1_item_reg.offset        <= req.offset;
            s1_item_reg.write_value   <= req.write_value;
            s1_item_reg.done_channel  <= req.done_channel;
            s1_item_reg.final_address <= req.final_address;
        end
        if (adv)
        begin
            rsp_beat_reg <= core_result;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.read_data       = rsp_beat_reg.read_data;
    assign rsp.irq_raise       = rsp_beat_reg.irq_raise;
    assign rsp.run_channel     = rsp_beat_reg.run_channel;
    assign rsp.channel_started = rsp_beat_reg.channel_started;

    // An interrupt can only come from a done event.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && core_result.irq_raise |-> s1_item_reg.op == dcr_pkg::OpDone)
        else $error("interrupt raised by a beat that is not a done event");

    // A started channel is a real channel and becomes the stored current channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && core_result.channel_started |=> cur_channel != dcr_pkg::NoneCh
            && cur_channel == $past(core_result.run_channel))
        else $error("started channel not held as current channel");

    // A held request beat is not lost while the response side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg)
        else $error("request stage dropped a beat");

    // The current channel is either none or one that exists.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_channel < 3'(NUM_CHANNELS)) || (cur_channel == dcr_pkg::NoneCh))
        else $error("current channel out of range");

endmodule

[sim/dcr_checker.sv]
// Checker that predicts every response beat of the DMA register block and compares it.
`timescale 1ns / 1ps

module dcr_checker (
    input  logic clk,
    input  logic rst_n,
    dcr_req_if   req,
    dcr_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   req_count,
    output int   rsp_count
);

    localparam int NumCh       = 7;
    localparam int IrqEnBase   = 16;
    localparam int IrqFlagBase = 24;
    localparam int IrqMaster   = 23;
    localparam int IrqFlag     = 31;

    // Shadow copy of the channel registers, global registers and arbiter state.
    logic [23:0] chan_addr [NumCh];
    logic [31:0] chan_blk  [NumCh];
    logic [31:0] chan_ctl  [NumCh];
    logic        chan_run  [NumCh];
    logic [31:0] prio_word;
    logic [31:0] irq_word;
    logic [2:0]  active_ch;

    dcr_pkg::out_beat_t expected_rsp [$];
    int fails;
    int n_req;
    int n_rsp;

    task automatic clear_shadow();
        for (int i = 0; i < NumCh; i++)
        begin
            chan_addr[i] = '0;
            chan_blk[i]  = '0;
            chan_ctl[i]  = '0;
            chan_run[i]  = 1'b0;
        end
        prio_word = dcr_pkg::PrioReset;
        irq_word  = '0;
        active_ch = dcr_pkg::NoneCh;
    endtask

    // The busy channel with the smallest key 8 + 8p - i wins; ties cannot occur.
    function automatic logic [2:0] arbitrate();
        logic [2:0] best;
        int lowest;
        int key;
        best   = dcr_pkg::NoneCh;
        lowest = 1 << 30;
        for (int i = 0; i < NumCh; i++)
        begin
            key = 8 + 8 * int'(prio_word[4*i +: 3]) - i;
            if (chan_run[i] && key < lowest)
            begin
                lowest = key;
                best   = 3'(i);
            end
        end
        return best;
    endfunction

    task automatic write_ctl(input int ch, input logic [31:0] v);
        logic [1:0] mode;
        if (ch == int'(dcr_pkg::OtcCh))
            chan_ctl[ch] = (v | dcr_pkg::OtcCtrlSet) & dcr_pkg::OtcCtrlMask;
        else
            chan_ctl[ch] = v & dcr_pkg::CtrlMask;
        if (v[dcr_pkg::StartBit])
        begin
            // A start on a channel not enabled in the priority word only stores the word.
            if (prio_word[4*ch + 3])
            begin
                mode = (ch == int'(dcr_pkg::OtcCh)) ? 2'b00 : chan_ctl[ch][10:9];
                if (mode == 2'b00)
                    chan_ctl[ch][dcr_pkg::TriggerBit] = 1'b0;
                chan_run[ch] = 1'b1;
                active_ch    = arbitrate();
            end
        end
        else if (chan_run[ch])
        begin
            chan_run[ch] = 1'b0;
            if (3'(ch) == active_ch)
                active_ch = arbitrate();
        end
    endtask

    task automatic apply_request(input dcr_pkg::in_beat_t b, output dcr_pkg::out_beat_t r);
        logic [2:0] ch;
        logic [3:0] rsel;
        logic [2:0] dch;
        logic [2:0] prev;
        ch   = b.offset[6:4];
        rsel = b.offset[3:0];
        dch  = b.done_channel;
        prev = active_ch;
        r    = '0;
        case (b.op)
            dcr_pkg::OpRead:
            begin
                if (ch == dcr_pkg::GlobalCh)
                    r.read_data = b.offset[2] ? irq_word : prio_word;
                else if (rsel == dcr_pkg::RegAddr)
                    r.read_data = {8'h00, chan_addr[ch]};
                else if (rsel == dcr_pkg::RegBlock)
                    r.read_data = chan_blk[ch];
                else if (rsel == dcr_pkg::RegCtrl)
                    r.read_data = chan_ctl[ch];
            end
            dcr_pkg::OpWrite:
            begin
                if (ch == dcr_pkg::GlobalCh)
                begin
                    if (b.offset[2])
                    begin
                        irq_word &= dcr_pkg::IrqKeepMask;
                        irq_word ^= (b.write_value & irq_word);
                        irq_word |= (b.write_value & dcr_pkg::IrqWrMask);
                    end
                    else
                        prio_word = b.write_value;
                end
                else if (rsel == dcr_pkg::RegAddr)
                    chan_addr[ch] = b.write_value[23:0];
                else if (rsel == dcr_pkg::RegBlock)
                    chan_blk[ch] = b.write_value;
                else if (rsel == dcr_pkg::RegCtrl)
                    write_ctl(int'(ch), b.write_value);
            end
            dcr_pkg::OpDone:
            begin
                if (int'(dch) < NumCh)
                begin
                    if (chan_run[dch])
                    begin
                        chan_addr[dch]                   = b.final_address;
                        chan_ctl[dch][dcr_pkg::StartBit] = 1'b0;
                        if (irq_word[IrqEnBase + dch])
                        begin
                            irq_word[IrqFlagBase + dch] = 1'b1;
                            if (irq_word[IrqMaster])
                            begin
                                irq_word[IrqFlag] = 1'b1;
                                r.irq_raise       = 1'b1;
                            end
                        end
                        chan_run[dch] = 1'b0;
                        if (dch == active_ch)
                            active_ch = arbitrate();
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.run_channel     = active_ch;
        r.channel_started = (active_ch != dcr_pkg::NoneCh) && (active_ch != prev);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        dcr_pkg::in_beat_t  b;
        dcr_pkg::out_beat_t want;
        dcr_pkg::out_beat_t got;
        if (!rst_n)
        begin
            clear_shadow();
            expected_rsp.delete();
            fails      = 0;
            n_req      = 0;
            n_rsp      = 0;
            fail_count <= 0;
            pending    <= 0;
            req_count  <= 0;
            rsp_count  <= 0;
        end
        else
        begin
            // A response at this edge always belongs to a request taken at an earlier edge.
            if (rsp.valid && rsp.ready)
            begin
                got.read_data       = rsp.read_data;
                got.irq_raise       = rsp.irq_raise;
                got.run_channel     = rsp.run_channel;
                got.channel_started = rsp.channel_started;
                n_rsp++;
                if (expected_rsp.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    fails++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("irq_raise", 32'(want.irq_raise), 32'(got.irq_raise));
                    check_field("run_channel", 32'(want.run_channel),
                                32'(got.run_channel));
                    check_field("channel_started", 32'(want.channel_started),
                                32'(got.channel_started));
                end
            end
            if (req.valid && req.ready)
            begin
                b.op            = req.op;
                b.offset        = req.offset;
                b.write_value   = req.write_value;
                b.done_channel  = req.done_channel;
                b.final_address = req.final_address;
                apply_request(b, want);
                expected_rsp.push_back(want);
                n_req++;
            end
            fail_count <= fails;
            pending    <= expected_rsp.size();
            req_count  <= n_req;
            rsp_count  <= n_rsp;
        end
    end

endmodule

[sim/tb_top.sv]
// Testbench top: clock, reset, request stimulus, response back-pressure and the verdict.
`timescale 1ns / 1ps

module tb_top;

    // The fourth opcode is not used by the block; it must come back as a plain status beat.
    localparam logic [1:0] OpUnused = 2'd3;

    // Register selects within the global group: bit 2 picks the interrupt word.
    localparam logic [3:0] GlbPrio = 4'h0;
    localparam logic [3:0] GlbIrq  = 4'h4;
    // A register select that decodes to nothing in a channel group.
    localparam logic [3:0] RegNone = 4'hC;

    // The watchdog allows several times the long response hold-off.
    localparam int HoldCycles    = 400;
    localparam int WatchdogLimit = 2000;

    logic clk = 1'b0;
    logic rst_n;

    dcr_req_if req_if ();
    dcr_rsp_if rsp_if ();

    int fail_count;
    int pending;
    int req_count;
    int rsp_count;

    // Idling switches, set by the stimulus and read by the request and response processes.
    bit src_idle_on;
    bit rcv_idle_on;
    bit hold_req;

    always #5 clk = ~clk;

    dma_channel_regs_arbiter_irq uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // The checker sees both channels and owns the prediction; the top only drives.
    dcr_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .rsp        (rsp_if),
        .fail_count (fail_count),
        .pending    (pending),
        .req_count  (req_count),
        .rsp_count  (rsp_count)
    );

    function automatic dcr_pkg::in_beat_t mk(input logic [1:0] op, input logic [6:0] off,
                                             input logic [31:0] val, input logic [2:0] dch,
                                             input logic [23:0] fadr);
        dcr_pkg::in_beat_t b;
        b.op            = op;
        b.offset        = off;
        b.write_value   = val;
        b.done_channel  = dch;
        b.final_address = fadr;
        return b;
    endfunction

    // Random traffic is mostly well-formed: control writes that start or stop channels and
    // done events on real channels, so that the arbiter and interrupt logic stay busy.
    // A small share is pure noise over every field, including the unused opcode.
    function automatic dcr_pkg::in_beat_t rand_beat();
        dcr_pkg::in_beat_t b;
        int sel;
        logic [2:0] ch;
        logic [3:0] rsel;
        b.op            = dcr_pkg::OpRead;
        b.offset        = 7'($urandom_range(0, 127));
        b.write_value   = $urandom;
        b.done_channel  = 3'($urandom_range(0, 7));
        b.final_address = 24'($urandom);
        sel = $urandom_range(0, 99);
        ch  = 3'($urandom_range(0, 6));
        if (sel < 28)
        begin
            // Start most of the time, stop otherwise.
            b.op     = dcr_pkg::OpWrite;
            b.offset = {ch, dcr_pkg::RegCtrl};
            b.write_value[dcr_pkg::StartBit] = ($urandom_range(0, 9) < 7);
        end
        else if (sel < 50)
        begin
            b.op           = dcr_pkg::OpDone;
            b.done_channel = ($urandom_range(0, 9) == 0) ? dcr_pkg::NoneCh : ch;
        end
        else if (sel < 70)
        begin
            b.op = dcr_pkg::OpRead;
            case ($urandom_range(0, 3))
                0: rsel = dcr_pkg::RegAddr;
                1: rsel = dcr_pkg::RegBlock;
                2: rsel = dcr_pkg::RegCtrl;
                default: rsel = 4'($urandom_range(0, 15));
            endcase
            b.offset = {3'($urandom_range(0, 7)), rsel};
        end
        else if (sel < 80)
        begin
            b.op     = dcr_pkg::OpWrite;
            b.offset = {ch, ($urandom_range(0, 1) == 0) ? dcr_pkg::RegAddr : dcr_pkg::RegBlock};
        end
        else if (sel < 85)
        begin
            // Priority words mostly keep every channel enabled.
            b.op     = dcr_pkg::OpWrite;
            b.offset = {dcr_pkg::GlobalCh, GlbPrio};
            if ($urandom_range(0, 9) < 8)
                b.write_value = b.write_value | 32'h0888_8888;
        end
        else if (sel < 92)
        begin
            // Interrupt writes force the master and channel enables on half the time.
            b.op     = dcr_pkg::OpWrite;
            b.offset = {dcr_pkg::GlobalCh, GlbIrq};
            if ($urandom_range(0, 1) == 0)
                b.write_value = b.write_value | 32'h00ff_8000;
        end
        else
            b.op = 2'($urandom_range(0, 3));
        return b;
    endfunction

    // Offer one beat and return at the edge where it is taken. Valid stays high into the
    // next beat unless a random gap is inserted first, so valid sees one update per step.
    task automatic send_beat(input dcr_pkg::in_beat_t b);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            req_if.valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.op            <= b.op;
        req_if.offset        <= b.offset;
        req_if.write_value   <= b.write_value;
        req_if.done_channel  <= b.done_channel;
        req_if.final_address <= b.final_address;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_beat(rand_beat());
    endtask

    // Drop valid and hold the sender back until the checker has seen every response.
    // It first lets the pending count take in the beat just taken.
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // Response side: ready is updated once per edge, with random stall bursts and one
    // long hold-off on request, counted here so the sender keeps pushing meanwhile.
    initial
    begin : receiver
        int stall;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HoldCycles - 1) @(posedge clk);
            end
            else if (rcv_idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_if.ready <= 1'b0;
                stall = $urandom_range(0, 12);
                repeat (stall) @(posedge clk);
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // The run ends with a failure if neither channel moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        dcr_pkg::in_beat_t directed [$];
        rst_n                <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.op            <= dcr_pkg::OpRead;
        req_if.offset        <= '0;
        req_if.write_value   <= '0;
        req_if.done_channel  <= '0;
        req_if.final_address <= '0;
        src_idle_on = 1'b1;
        rcv_idle_on = 1'b1;
        hold_req    = 1'b0;

        // Reset state of both global words.
        directed.push_back(mk(dcr_pkg::OpRead, {dcr_pkg::GlobalCh, GlbPrio}, 32'h0, 3'd0,
                              24'h0));
        directed.push_back(mk(dcr_pkg::OpRead, {dcr_pkg::GlobalCh, GlbIrq}, 32'h0, 3'd0,
                              24'h0));
        // Start while the channel is disabled in the priority word, then a done on an
        // idle channel; neither may start anything.
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd0, dcr_pkg::RegCtrl}, 32'h0100_0000,
                              3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpDone, 7'h00, 32'h0, 3'd0, 24'h12_3456));
        // Enable all channels and all interrupts with the master bit.
        directed.push_back(mk(dcr_pkg::OpWrite, {dcr_pkg::GlobalCh, GlbPrio}, 32'h0FED_CBA9,
                              3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpWrite, {dcr_pkg::GlobalCh, GlbIrq}, 32'hFFFF_FFFF,
                              3'd0, 24'h0));
        // Non-burst start keeps the trigger bit; burst starts clear it.
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd3, dcr_pkg::RegCtrl}, 32'h7100_0200,
                              3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd5, dcr_pkg::RegCtrl}, 32'h1100_0000,
                              3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpWrite, {dcr_pkg::OtcCh, dcr_pkg::RegCtrl},
                              32'hFFFF_FFFF, 3'd0, 24'h0));
        // New priorities must not re-arbitrate the running channel.
        directed.push_back(mk(dcr_pkg::OpWrite, {dcr_pkg::GlobalCh, GlbPrio}, 32'h0888_8888,
                              3'd0, 24'h0));
        // Done on a busy channel that is not the active one, at the top address.
        directed.push_back(mk(dcr_pkg::OpDone, 7'h00, 32'h0, 3'd5, 24'hFF_FFFF));
        directed.push_back(mk(dcr_pkg::OpRead, {3'd5, dcr_pkg::RegCtrl}, 32'h0, 3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpRead, {3'd5, dcr_pkg::RegAddr}, 32'h0, 3'd0, 24'h0));
        // Stopping the active channel hands over to the remaining busy one.
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd3, dcr_pkg::RegCtrl}, 32'h0000_0000,
                              3'd0, 24'h0));
        // Start and stop a busy channel that does not win.
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd1, dcr_pkg::RegCtrl}, 32'h0100_0000,
                              3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd1, dcr_pkg::RegCtrl}, 32'h0000_0000,
                              3'd0, 24'h0));
        // Done on the active channel leaves nothing running; the absent channel is ignored.
        directed.push_back(mk(dcr_pkg::OpDone, 7'h00, 32'h0, dcr_pkg::OtcCh, 24'h00_0000));
        directed.push_back(mk(dcr_pkg::OpDone, 7'h7F, 32'hFFFF_FFFF, dcr_pkg::NoneCh,
                              24'hFF_FFFF));
        // Full-width data words and the truncated address register.
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd2, dcr_pkg::RegBlock}, 32'hFFFF_FFFF,
                              3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd2, dcr_pkg::RegAddr}, 32'hFFFF_FFFF,
                              3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpRead, {3'd2, dcr_pkg::RegAddr}, 32'h0, 3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpRead, {3'd2, dcr_pkg::RegBlock}, 32'h0, 3'd0,
                              24'h0));
        // Register selects that decode to nothing.
        directed.push_back(mk(dcr_pkg::OpWrite, {3'd2, RegNone}, 32'hFFFF_FFFF, 3'd0, 24'h0));
        directed.push_back(mk(dcr_pkg::OpRead, {3'd2, RegNone}, 32'h0, 3'd0, 24'h0));
        // Clearing the sticky flags, then the unused opcode and a read through the all-ones offset.
        directed.push_back(mk(dcr_pkg::OpWrite, {dcr_pkg::GlobalCh, GlbIrq}, 32'h7F00_0000,
                              3'd0, 24'h0));
        directed.push_back(mk(OpUnused, 7'h7F, 32'hFFFF_FFFF, 3'd7, 24'hFF_FFFF));
        directed.push_back(mk(dcr_pkg::OpRead, 7'h7F, 32'h0, 3'd0, 24'h0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_beat(directed[i]);

        send_random(700);

        // Long response hold-off: the sender keeps offering at full rate until the block
        // fills up and drops ready, then the sender waits for everything to come back.
        src_idle_on = 1'b0;
        hold_req    = 1'b1;
        send_random(40);
        drain();
        src_idle_on = 1'b1;

        send_random(700);

        // Last stretch at full rate on both sides.
        src_idle_on = 1'b0;
        rcv_idle_on = 1'b0;
        send_random(360);

        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d request beats and checked %0d response beats.", req_count,
                 rsp_count);
        $display("Covered corner cases, bursty idling, a long hold-off and full rate.");
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
